FILE: sv/rbs_pkg.sv
package rbs_pkg;

   // configuration register map
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_BOX_MIN_X = 3'd0,
      REG_BOX_MIN_Y = 3'd1,
      REG_BOX_MIN_Z = 3'd2,
      REG_BOX_MAX_X = 3'd3,
      REG_BOX_MAX_Y = 3'd4,
      REG_BOX_MAX_Z = 3'd5
   } rbs_reg_index_type;

   localparam int NUM_AXES    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int FLAG_WIDTH  = 4;

   // per-axis classification made at accept time
   typedef struct packed {
      logic par_miss;   // direction zero and origin outside the slab
      logic dir_zero;   // parallel to this slab
      logic neg_hi;     // upper-plane quotient is negative
      logic neg_lo;     // lower-plane quotient is negative
   } rbs_axis_flags_type;

endpackage

FILE: sv/rbs_queue.sv
module rbs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   output logic             full
);
   import rbs_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff;
   logic [PW-1:0]    rp_ff;
   logic [PW:0]      cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (cnt_ff == (PW+1)'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (do_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

FILE: sv/rbs_front.sv
module rbs_front #(
   parameter int CW = 32
) (
   input  logic signed [CW-1:0] box_lo [3],
   input  logic signed [CW-1:0] box_hi [3],
   input  logic signed [CW-1:0] org [3],
   input  logic signed [CW-1:0] dir [3],
   input  logic signed [CW-1:0] t_start,
   input  logic signed [CW-1:0] t_end,
   output logic [3*(5*CW+6)+2*CW-1:0] item
);
   import rbs_pkg::*;

   localparam int AXW = 5*CW + 6;

   logic [AXW-1:0] lane [3];

   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
      logic signed [CW:0]  dlo;
      logic signed [CW:0]  dhi;
      logic [CW:0]         ulo;
      logic [CW:0]         uhi;
      logic [CW-1:0]       ud;
      rbs_axis_flags_type  flags;

      always_comb begin
         dlo = $signed({box_lo[ax][CW-1], box_lo[ax]}) - $signed({org[ax][CW-1], org[ax]});
         dhi = $signed({box_hi[ax][CW-1], box_hi[ax]}) - $signed({org[ax][CW-1], org[ax]});
         ulo = dlo[CW] ? (~dlo + 1'b1) : dlo;
         uhi = dhi[CW] ? (~dhi + 1'b1) : dhi;
         ud  = dir[ax][CW-1] ? (~dir[ax] + 1'b1) : dir[ax];
         flags.neg_lo   = dlo[CW] ^ dir[ax][CW-1];
         flags.neg_hi   = dhi[CW] ^ dir[ax][CW-1];
         flags.dir_zero = (dir[ax] == '0);
         flags.par_miss = flags.dir_zero && ((org[ax] < box_lo[ax]) || (org[ax] > box_hi[ax]));
      end

      assign lane[ax] = {flags, org[ax], dir[ax], ud, uhi, ulo};
   end

   assign item = {t_end, t_start, lane[2], lane[1], lane[0]};

endmodule

FILE: sv/rbs_divider.sv
module rbs_divider #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                clock,
   input  logic [CW+FB:0]      num,
   input  logic [CW-1:0]       den,
   output logic [CW+FB:0]      quo
);
   import rbs_pkg::*;

   localparam int QW = CW + 1 + FB;

   // restoring division, one quotient bit per stage; numerator bits shift
   // out of the top of nq while quotient bits shift in at the bottom
   function automatic logic [CW+QW-1:0] div_step(input logic [CW-1:0] rem,
                                                 input logic [QW-1:0] nq,
                                                 input logic [CW-1:0] d);
      logic [CW:0]   t;
      logic [CW:0]   diff;
      logic [CW-1:0] r;
      logic          b;
      t    = {rem, nq[QW-1]};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         r = diff[CW-1:0];
         b = 1'b1;
      end else begin
         r = t[CW-1:0];
         b = 1'b0;
      end
      return {r, nq[QW-2:0], b};
   endfunction

   logic [CW-1:0]    rem_ff [QW];
   logic [QW-1:0]    nq_ff  [QW];
   logic [CW-1:0]    den_ff [QW];
   logic [CW+QW-1:0] step_in [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign step_in[k] = div_step('0, num, den);
         always_ff @(posedge clock) begin
            den_ff[k] <= den;
         end
      end else begin : g_next
         assign step_in[k] = div_step(rem_ff[k-1], nq_ff[k-1], den_ff[k-1]);
         always_ff @(posedge clock) begin
            den_ff[k] <= den_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         {rem_ff[k], nq_ff[k]} <= step_in[k];
      end
   end

   assign quo = nq_ff[QW-1];

endmodule

FILE: sv/rbs_back.sv
module rbs_back #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [3*(5*CW+6)+2*CW-1:0]    in_item,
   output logic                          out_valid,
   output logic                          out_hit,
   output logic signed [CW-1:0]          out_t_near,
   output logic signed [CW-1:0]          out_t_far,
   output logic signed [CW-1:0]          out_point [3]
);
   import rbs_pkg::*;

   localparam int QW  = CW + 1 + FB;
   localparam int AXW = 5*CW + 6;
   localparam int IW  = 3*AXW + 2*CW;
   localparam int O_UHI = CW + 1;
   localparam int O_UD  = 2*CW + 2;
   localparam int O_DIR = 3*CW + 2;
   localparam int O_ORG = 4*CW + 2;
   localparam int O_FLG = 5*CW + 2;
   localparam logic signed [2*CW:0] SMAX = {{(CW+2){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [2*CW:0] SMIN = {{(CW+2){1'b1}}, {(CW-1){1'b0}}};

   function automatic logic [CW-1:0] qsat(input logic [QW-1:0] q, input logic neg);
      logic big;
      logic at_min;
      big    = |q[QW-1:CW-1];
      at_min = (q[QW-1:CW-1] == {{(QW-CW){1'b0}}, 1'b1}) && (q[CW-2:0] == '0);
      if (neg) begin
         if (big && !at_min) begin
            return {1'b1, {(CW-1){1'b0}}};
         end
         return ~q[CW-1:0] + 1'b1;
      end
      if (big) begin
         return {1'b0, {(CW-1){1'b1}}};
      end
      return q[CW-1:0];
   endfunction

   // ---- divider lanes and matching sideband line
   logic [QW-1:0] quo [3][2];
   logic [QW-1:0] vld_ff;
   logic [IW-1:0] side_ff [QW];

   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_div
      rbs_divider #(.CW(CW), .FB(FB)) u_div_lo (
         .clock (clock),
         .num   ({in_item[ax*AXW +: CW+1], {FB{1'b0}}}),
         .den   (in_item[ax*AXW+O_UD +: CW]),
         .quo   (quo[ax][0])
      );
      rbs_divider #(.CW(CW), .FB(FB)) u_div_hi (
         .clock (clock),
         .num   ({in_item[ax*AXW+O_UHI +: CW+1], {FB{1'b0}}}),
         .den   (in_item[ax*AXW+O_UD +: CW]),
         .quo   (quo[ax][1])
      );
   end

   for (genvar k = 0; k < QW; k++) begin : g_side
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            side_ff[k] <= in_item;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QW-2:0], in_valid};
      end
   end

   // ---- saturate stage (index 0) and one stage per axis (1..3)
   logic [3:0]           vs_ff;
   logic                 hit_ff [4];
   logic signed [CW-1:0] tn_ff  [4];
   logic signed [CW-1:0] tf_ff  [4];
   logic signed [CW-1:0] a_ff   [4][3];
   logic signed [CW-1:0] b_ff   [4][3];
   logic [IW-1:0]        it_ff  [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= '0;
      end else begin
         vs_ff <= {vs_ff[2:0], vld_ff[QW-1]};
      end
   end

   always_ff @(posedge clock) begin
      hit_ff[0] <= 1'b1;
      tn_ff[0]  <= side_ff[QW-1][3*AXW +: CW];
      tf_ff[0]  <= side_ff[QW-1][3*AXW+CW +: CW];
      it_ff[0]  <= side_ff[QW-1];
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         a_ff[0][ax] <= qsat(quo[ax][0], side_ff[QW-1][ax*AXW+O_FLG]);
         b_ff[0][ax] <= qsat(quo[ax][1], side_ff[QW-1][ax*AXW+O_FLG+1]);
      end
   end

   for (genvar st = 0; st < NUM_AXES; st++) begin : g_slab
      rbs_axis_flags_type   flags;
      logic signed [CW-1:0] lo_q;
      logic signed [CW-1:0] hi_q;
      logic signed [CW-1:0] small_q;
      logic signed [CW-1:0] large_q;
      logic signed [CW-1:0] ntn;
      logic signed [CW-1:0] ntf;
      logic signed [CW-1:0] tn_in;
      logic signed [CW-1:0] tf_in;
      logic                 hit_in;

      always_comb begin
         flags   = rbs_axis_flags_type'(it_ff[st][st*AXW+O_FLG +: FLAG_WIDTH]);
         lo_q    = a_ff[st][st];
         hi_q    = b_ff[st][st];
         // equal quotients: upper plane counts as the smaller one
         small_q = (lo_q < hi_q) ? lo_q : hi_q;
         large_q = (lo_q < hi_q) ? hi_q : lo_q;
         ntn     = (small_q > tn_ff[st]) ? small_q : tn_ff[st];
         ntf     = (large_q < tf_ff[st]) ? large_q : tf_ff[st];
         tn_in   = tn_ff[st];
         tf_in   = tf_ff[st];
         hit_in  = hit_ff[st];
         if (hit_ff[st]) begin
            if (!flags.dir_zero) begin
               tn_in  = ntn;
               tf_in  = ntf;
               hit_in = !(ntn > ntf);
            end else begin
               hit_in = !flags.par_miss;
            end
         end
      end

      always_ff @(posedge clock) begin
         hit_ff[st+1] <= hit_in;
         tn_ff[st+1]  <= tn_in;
         tf_ff[st+1]  <= tf_in;
         it_ff[st+1]  <= it_ff[st];
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            a_ff[st+1][ax] <= a_ff[st][ax];
            b_ff[st+1][ax] <= b_ff[st][ax];
         end
      end
   end

   // ---- multiply stage
   logic                   vm_ff;
   logic                   hm_ff;
   logic signed [CW-1:0]   tnm_ff;
   logic signed [CW-1:0]   tfm_ff;
   logic signed [2*CW-1:0] prod_ff [3];
   logic signed [CW-1:0]   orgm_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else begin
         vm_ff <= vs_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      hm_ff  <= hit_ff[3];
      tnm_ff <= tn_ff[3];
      tfm_ff <= tf_ff[3];
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         prod_ff[ax] <= $signed(it_ff[3][ax*AXW+O_DIR +: CW]) * tn_ff[3];
         orgm_ff[ax] <= $signed(it_ff[3][ax*AXW+O_ORG +: CW]);
      end
   end

   // ---- entry point: floor shift, add origin, saturate; zero on a miss
   logic                 vo_ff;
   logic                 ho_ff;
   logic signed [CW-1:0] tno_ff;
   logic signed [CW-1:0] tfo_ff;
   logic signed [CW-1:0] pt_ff [3];
   logic signed [CW-1:0] pt_in [3];

   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_point
      logic signed [2*CW-1:0] sh;
      logic signed [2*CW:0]   sum;
      always_comb begin
         sh  = prod_ff[ax] >>> FB;
         sum = $signed({{(CW+1){orgm_ff[ax][CW-1]}}, orgm_ff[ax]}) + $signed({sh[2*CW-1], sh});
         if (!hm_ff) begin
            pt_in[ax] = '0;
         end else if (sum > SMAX) begin
            pt_in[ax] = SMAX[CW-1:0];
         end else if (sum < SMIN) begin
            pt_in[ax] = SMIN[CW-1:0];
         end else begin
            pt_in[ax] = sum[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      ho_ff  <= hm_ff;
      tno_ff <= tnm_ff;
      tfo_ff <= tfm_ff;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         pt_ff[ax] <= pt_in[ax];
      end
   end

   assign out_valid  = vo_ff;
   assign out_hit    = ho_ff;
   assign out_t_near = tno_ff;
   assign out_t_far  = tfo_ff;
   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_out
      assign out_point[ax] = pt_ff[ax];
   end

endmodule

FILE: sv/ray_box_slab_intersect.sv
// channel   ports                               transfer when
// --------  ----------------------------------  ------------------------------
// request   start, busy, req_*                  start high and busy low
// response  rsp_valid, rsp_*                    rsp_valid high (one cycle)
// csr       csr_valid, csr_ready, csr_index,    csr_valid and csr_ready high
//           csr_wdata
//
// One request per cycle sustained while busy is low. A response passes the
// queue, the slab dividers (which retire one quotient bit per stage), and
// the saturate, slab, multiply and entry-point stages.
// Reset (synchronous, high) clears the box registers and all valid bits.
// busy rises only if the two-entry queue fills; the back end drains it
// every cycle. The response side has no backpressure.
module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COORD_WIDTH-1:0]        req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]        req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]        req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]        req_dir_x,
   input  logic signed [COORD_WIDTH-1:0]        req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]        req_dir_z,
   input  logic signed [COORD_WIDTH-1:0]        req_t_start,
   input  logic signed [COORD_WIDTH-1:0]        req_t_end,
   // response
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic signed [COORD_WIDTH-1:0]        rsp_t_near,
   output logic signed [COORD_WIDTH-1:0]        rsp_t_far,
   output logic signed [COORD_WIDTH-1:0]        rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]        rsp_point_y,
   output logic signed [COORD_WIDTH-1:0]        rsp_point_z,
   // box registers
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rbs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]               csr_wdata
);
   import rbs_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int QW  = CW + 1 + FRAC_BITS;
   localparam int IW  = 3*(5*CW + 6) + 2*CW;
   localparam int LAT = QW + 7;

   // ---- box registers; always ready, sampled by the front at request transfer
   logic signed [CW-1:0] box_lo_ff [3];
   logic signed [CW-1:0] box_hi_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            box_lo_ff[ax] <= '0;
            box_hi_ff[ax] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (rbs_reg_index_type'(csr_index))
            REG_BOX_MIN_X: box_lo_ff[0] <= csr_wdata;
            REG_BOX_MIN_Y: box_lo_ff[1] <= csr_wdata;
            REG_BOX_MIN_Z: box_lo_ff[2] <= csr_wdata;
            REG_BOX_MAX_X: box_hi_ff[0] <= csr_wdata;
            REG_BOX_MAX_Y: box_hi_ff[1] <= csr_wdata;
            REG_BOX_MAX_Z: box_hi_ff[2] <= csr_wdata;
            default:       ;  // unmapped index, dropped
         endcase
      end
   end

   // ---- front: classify per axis and push into the queue
   logic signed [CW-1:0] org [3];
   logic signed [CW-1:0] dir [3];
   logic [IW-1:0]        front_item;
   logic                 accept;
   logic                 q_valid;
   logic [IW-1:0]        q_item;
   logic                 q_full;

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   rbs_front #(.CW(CW)) u_front (
      .box_lo  (box_lo_ff),
      .box_hi  (box_hi_ff),
      .org     (org),
      .dir     (dir),
      .t_start (req_t_start),
      .t_end   (req_t_end),
      .item    (front_item)
   );

   assign busy   = q_full;
   assign accept = start && !busy;

   rbs_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_item),
      .pop       (q_valid),
      .pop_valid (q_valid),
      .pop_data  (q_item),
      .full      (q_full)
   );

   // ---- back: dividers, slab narrowing, entry point
   logic signed [CW-1:0] point [3];

   rbs_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_item    (q_item),
      .out_valid  (rsp_valid),
      .out_hit    (rsp_hit),
      .out_t_near (rsp_t_near),
      .out_t_far  (rsp_t_far),
      .out_point  (point)
   );

   assign rsp_point_x = point[0];
   assign rsp_point_y = point[1];
   assign rsp_point_z = point[2];

   // ---- checks
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request transfer without response");

   a_resp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without request");

   a_miss_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0))
      else $error("miss with nonzero entry point");

endmodule
